// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file lbb_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed: always");

// when ante holds, cons must hold at the next edge
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next");

`endif

// ===== hw/rtl/lbb_pkg.sv =====
`timescale 1ns / 1ps

package lbb_pkg;

   // command codes carried in func
   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_PLAY       = 3'd1;
   localparam logic [2:0] FUNC_STOP_PLAY  = 3'd2;
   localparam logic [2:0] FUNC_BLINK      = 3'd3;
   localparam logic [2:0] FUNC_STOP_BLINK = 3'd4;

   // register indexes
   localparam logic [1:0] REG_BREATH_STEP = 2'd0;
   localparam logic [1:0] REG_BLINK_STEP  = 2'd1;
   localparam logic [1:0] REG_REST        = 2'd2;

   localparam int CURVE_LENGTH = 70;
   localparam int TABLE_DEPTH  = 70;

   localparam logic [7:0] LEVEL_TABLE [0:TABLE_DEPTH-1] = '{
      8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd4,   8'd5,   8'd7,
      8'd9,   8'd12,  8'd16,  8'd21,  8'd28,  8'd37,  8'd48,  8'd64,  8'd84,  8'd111,
      8'd147, 8'd193, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd218, 8'd186, 8'd159, 8'd135, 8'd116, 8'd99,
      8'd84,  8'd72,  8'd61,  8'd52,  8'd45,  8'd38,  8'd33,  8'd28,  8'd24,  8'd20,
      8'd17,  8'd15,  8'd13,  8'd11,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,
      8'd4,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0
   };

   typedef struct packed {
      logic [15:0] breath_step_ticks;
      logic [15:0] blink_step_ticks;
      logic [15:0] rest_ticks;
   } cfg_type;

   typedef struct packed {
      logic       is_blinking;
      logic       is_playing;
      logic       led_level;
      logic       pwm_running;
      logic       pwm_pin_driven;
      logic [7:0] pwm_duty;
   } res_type;

   // brightness curve, entries past the table read as zero
   function automatic logic [7:0] level_at(input logic [6:0] idx);
      logic [7:0] lvl;
      lvl = 8'd0;
      if (int'(idx) < TABLE_DEPTH) begin
         lvl = LEVEL_TABLE[idx];
      end
      return lvl;
   endfunction

endpackage

// ===== hw/rtl/lbb_engine.sv =====
`timescale 1ns / 1ps

module lbb_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [2:0]       func,
   input  logic [7:0]       flash_count,
   input  lbb_pkg::cfg_type cfg,
   output lbb_pkg::res_type state_now
);
   import lbb_pkg::*;

   logic        playing_ff, playing_in;
   logic        blinking_ff, blinking_in;
   logic [7:0]  target_ff, target_in;
   logic [8:0]  phase_ff, phase_in;
   logic [6:0]  index_ff, index_in;
   logic [7:0]  duty_ff, duty_in;
   logic        conn_ff, conn_in;
   logic        timer_ff, timer_in;
   logic        level_ff, level_in;
   logic [16:0] breath_cd_ff, breath_cd_in;
   logic [15:0] blink_cd_ff, blink_cd_in;
   // a breath step was taken and its level sits in the rom read register
   logic        pend_duty_ff, pend_duty_in;
   logic        pend_lvl_ff, pend_lvl_in;
   logic [7:0]  rom_q_ff;
   logic        rom_rd;
   logic [6:0]  rom_addr;

   logic        eff_conn, eff_level;
   logic [7:0]  eff_duty;
   logic [6:0]  index_inc;

   // resolve a pending step against the registered rom word
   always_comb begin
      eff_duty  = pend_duty_ff ? rom_q_ff : duty_ff;
      eff_conn  = pend_duty_ff ? (rom_q_ff != 8'd0) : conn_ff;
      eff_level = (pend_lvl_ff && (rom_q_ff == 8'd0)) ? 1'b0 : level_ff;
   end

   assign index_inc = index_ff + 7'd1;

   always_comb begin
      playing_in   = playing_ff;
      blinking_in  = blinking_ff;
      target_in    = target_ff;
      phase_in     = phase_ff;
      index_in     = index_ff;
      duty_in      = duty_ff;
      conn_in      = conn_ff;
      timer_in     = timer_ff;
      level_in     = level_ff;
      breath_cd_in = breath_cd_ff;
      blink_cd_in  = blink_cd_ff;
      pend_duty_in = pend_duty_ff;
      pend_lvl_in  = pend_lvl_ff;
      rom_rd       = 1'b0;
      rom_addr     = index_inc;
      if (step_en) begin
         duty_in      = eff_duty;
         conn_in      = eff_conn;
         level_in     = eff_level;
         pend_duty_in = 1'b0;
         pend_lvl_in  = 1'b0;
         unique case (func)
            FUNC_TICK: begin
               if (playing_ff) begin
                  if (breath_cd_ff <= 17'd1) begin
                     rom_rd       = 1'b1;
                     pend_duty_in = 1'b1;
                     pend_lvl_in  = 1'b1;
                     if (index_inc == 7'(CURVE_LENGTH - 1)) begin
                        rom_addr     = 7'd0;
                        index_in     = 7'd0;
                        breath_cd_in = {1'b0, cfg.breath_step_ticks}
                                     + {1'b0, cfg.rest_ticks};
                     end else begin
                        index_in     = index_inc;
                        breath_cd_in = {1'b0, cfg.breath_step_ticks};
                     end
                  end else begin
                     breath_cd_in = breath_cd_ff - 17'd1;
                  end
               end
               if (blinking_ff) begin
                  if (blink_cd_ff <= 16'd1) begin
                     pend_lvl_in = 1'b0;
                     phase_in    = phase_ff + 9'd1;
                     if (phase_ff[0]) begin
                        level_in = 1'b0;
                        if (phase_ff[8:1] == target_ff) begin
                           // last flash: clear target and blinking, and set the phase to one
                           target_in   = 8'd0;
                           blinking_in = 1'b0;
                           phase_in    = 9'd1;
                        end
                     end else begin
                        level_in = 1'b1;
                     end
                     blink_cd_in = cfg.blink_step_ticks;
                  end else begin
                     blink_cd_in = blink_cd_ff - 16'd1;
                  end
               end
            end
            FUNC_PLAY: begin
               if (!playing_ff) begin
                  conn_in      = 1'b1;
                  timer_in     = 1'b1;
                  index_in     = 7'd0;
                  playing_in   = 1'b1;
                  breath_cd_in = {1'b0, cfg.breath_step_ticks};
               end
            end
            FUNC_STOP_PLAY: begin
               conn_in    = 1'b0;
               timer_in   = 1'b0;
               level_in   = 1'b0;
               index_in   = 7'd0;
               playing_in = 1'b0;
            end
            FUNC_BLINK: begin
               conn_in  = 1'b0;
               timer_in = 1'b0;
               level_in = 1'b0;
               if (!blinking_ff) begin
                  phase_in    = 9'd0;
                  target_in   = flash_count;
                  blinking_in = 1'b1;
                  blink_cd_in = cfg.blink_step_ticks;
               end
            end
            FUNC_STOP_BLINK: begin
               phase_in    = 9'd0;
               target_in   = 8'd0;
               blinking_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff   <= 1'b0;
         blinking_ff  <= 1'b0;
         target_ff    <= 8'd0;
         phase_ff     <= 9'd0;
         index_ff     <= 7'd0;
         duty_ff      <= 8'd0;
         conn_ff      <= 1'b1;
         timer_ff     <= 1'b1;
         level_ff     <= 1'b0;
         breath_cd_ff <= 17'd0;
         blink_cd_ff  <= 16'd0;
         pend_duty_ff <= 1'b0;
         pend_lvl_ff  <= 1'b0;
      end else begin
         playing_ff   <= playing_in;
         blinking_ff  <= blinking_in;
         target_ff    <= target_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         duty_ff      <= duty_in;
         conn_ff      <= conn_in;
         timer_ff     <= timer_in;
         level_ff     <= level_in;
         breath_cd_ff <= breath_cd_in;
         blink_cd_ff  <= blink_cd_in;
         pend_duty_ff <= pend_duty_in;
         pend_lvl_ff  <= pend_lvl_in;
      end
   end

   // curve rom, registered read
   always_ff @(posedge clock) begin
      if (rom_rd) begin
         rom_q_ff <= level_at(rom_addr);
      end
   end

   always_comb begin
      state_now.pwm_duty       = eff_duty;
      state_now.pwm_pin_driven = eff_conn;
      state_now.pwm_running    = timer_ff;
      state_now.led_level      = eff_level;
      state_now.is_playing     = playing_ff;
      state_now.is_blinking    = blinking_ff;
   end

endmodule

// ===== hw/rtl/led_breathe_blink_controller.sv =====
`timescale 1ns / 1ps
// a taken request word updates the engine state registers; that state is then
//   loaded into the result register when that slot is free or draining
// throughput: one word per cycle unless rsp_tready stalls; the curve rom's
//   registered read resolves the cycle after a step, alongside the next update
// reset: synchronous, active high; all control state and the config return to
//   their defaults, no clearing pass; rom and rsp data are not reset

module led_breathe_blink_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] func, [10:3] flash_count, rest zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] pwm_duty, [8] pwm_pin_driven,
                                    // [9] pwm_running, [10] led_level,
                                    // [11] is_playing, [12] is_blinking
   // register write port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import lbb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        s1_valid_ff, s1_valid_in;   // a word's state waits to be sampled
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_data_ff;
   res_type     state_now;
   logic        out_load;
   logic        req_acc;

   // config registers: user writes them only while idle; not enforced here
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_BREATH_STEP: cfg_in.breath_step_ticks = csr_wdata;
            REG_BLINK_STEP:  cfg_in.blink_step_ticks  = csr_wdata;
            REG_REST:        cfg_in.rest_ticks        = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // the state after a taken word is visible in the following cycle; it moves to the
   // output register when that slot is free or draining
   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || out_load;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.breath_step_ticks <= 16'd32;
         cfg_ff.blink_step_ticks  <= 16'd50;
         cfg_ff.rest_ticks        <= 16'd3000;
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= state_now;
      end
   end

   lbb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_acc),
      .func        (req_tdata[2:0]),
      .flash_count (req_tdata[10:3]),
      .cfg         (cfg_ff),
      .state_now   (state_now)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};

endmodule

// ===== hw/rtl/lbb_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   logic [1:0] inflight_ff;
   logic [1:0] inflight_in;
   logic       acc_in, acc_out;

   assign acc_in  = req_tvalid && req_tready;
   assign acc_out = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (acc_in && !acc_out) begin
         inflight_in = inflight_ff + 2'd1;
      end else if (!acc_in && acc_out) begin
         inflight_in = inflight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 2'd0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `CHK_NEXT(rsp_hold_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CHK_NEXT(rsp_hold_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // no result without a request in flight
   `CHK_ALWAYS(no_invented_word, clock, reset, (inflight_ff != 2'd0) || !rsp_tvalid)
   // at most two words between input and output
   `CHK_ALWAYS(inflight_bounded, clock, reset, inflight_ff != 2'd3)

endmodule

bind led_breathe_blink_controller lbb_checker u_lbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
